/* design/mfp_pkg.sv */
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared constants, types and codes of the motor feedback frame parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

    // Position of the last byte of a frame; the frame holds positions 0 to this.
    localparam int FRAME_LAST_INDEX = 25;
    localparam int STORE_DEPTH      = FRAME_LAST_INDEX + 1;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);

    // One scan step per store read, plus five to fill the six-byte window.
    localparam int SCAN_END = FRAME_LAST_INDEX + 5;
    localparam int STEP_W   = $clog2(SCAN_END + 1);

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;

    localparam logic [BYTE_W-1:0] SEP_CHAR = 8'h3B;
    localparam logic [BYTE_W-1:0] CR_CHAR  = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_CHAR  = 8'h0A;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER_CHAR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_CHAR  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_CHAR    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_TAG    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_TAG   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_CENTER_TAG  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_SCAN,
        ST_EMIT
    } mfp_state_t;

    typedef struct packed {
        logic shift;
        logic eval;
    } scan_ctrl_t;

    typedef struct packed {
        logic [BYTE_W-1:0] time_tag;
        logic [BYTE_W-1:0] left_tag;
        logic [BYTE_W-1:0] right_tag;
        logic [BYTE_W-1:0] center_tag;
    } mfp_tags_t;

endpackage

/* design/mfp_ram.sv */
// ----------------------------------------------------------------------------
// mfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* design/mfp_scan_unit.sv */
// ----------------------------------------------------------------------------
// mfp_scan_unit
// Six-byte sliding window over the frame store, tag matcher and held values.
// ----------------------------------------------------------------------------
module mfp_scan_unit
    import mfp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  scan_ctrl_t          ctrl,
    input  logic [BYTE_W-1:0]   scan_byte,
    input  mfp_tags_t           tags,
    output logic [VALUE_W-1:0]  held_time,
    output logic [VALUE_W-1:0]  held_left,
    output logic [VALUE_W-1:0]  held_right,
    output logic [VALUE_W-1:0]  held_center,
    output logic                crlf_hit
);

    logic [BYTE_W-1:0]  win_reg [5];
    logic [BYTE_W-1:0]  tag_byte;
    logic [BYTE_W-1:0]  next_byte;
    logic               sep_ok;
    logic [VALUE_W-1:0] word;
    logic [VALUE_W-1:0] held_time_reg, held_left_reg, held_right_reg, held_center_reg;

    // The window plus the byte arriving now covers positions p to p+5.
    assign tag_byte  = win_reg[0];
    assign next_byte = win_reg[1];
    assign word      = {win_reg[1], win_reg[2], win_reg[3], win_reg[4]};
    assign sep_ok    = ctrl.eval && (scan_byte == SEP_CHAR);
    assign crlf_hit  = ctrl.eval && (tag_byte == CR_CHAR) && (next_byte == LF_CHAR);

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            for (int i = 0; i < 4; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[4] <= scan_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_time_reg   <= '0;
            held_left_reg   <= '0;
            held_right_reg  <= '0;
            held_center_reg <= '0;
        end else begin
            if (sep_ok && (tag_byte == tags.time_tag)) begin
                held_time_reg <= word;
            end
            if (sep_ok && (tag_byte == tags.left_tag)) begin
                held_left_reg <= word;
            end
            if (sep_ok && (tag_byte == tags.right_tag)) begin
                held_right_reg <= word;
            end
            if (sep_ok && (tag_byte == tags.center_tag)) begin
                held_center_reg <= word;
            end
        end
    end

    assign held_time   = held_time_reg;
    assign held_left   = held_left_reg;
    assign held_right  = held_right_reg;
    assign held_center = held_center_reg;

endmodule

/* design/motor_feedback_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// motor_feedback_frame_parser_unit
// Assembles serial bytes into fixed-length frames and decodes tagged values.
// ----------------------------------------------------------------------------
// Bytes enter on the s_ channel, one per transaction. A frame opens when the
// start byte follows the header byte and closes on the byte written at the
// last frame position. Only the closing byte yields a result on the m_
// channel: m_tuser carries frame_ok and m_tdata the four held values.
// An ordinary byte is accepted in ST_IDLE alone; the start byte also passes
// through ST_HDR: header and start bytes enter the store one per cycle.
// A malformed closing byte moves to ST_EMIT, which loads the output register
// and raises m_tvalid once that register is free. A good closing byte runs a
// scan over the store, one read a cycle through a single RAM port, ending
// early after a CR LF pair, and then moves to ST_EMIT in the same way.
// s_tready is low while a start byte, scan or result load is in progress.
// The result sits in an output register, so bytes keep flowing while the
// receiver stalls; only a further result waits for that register to free.
// Reset clears the frame state, the held values and the result valid, and
// loads the configuration registers with their defaults. The frame store
// needs no clearing: every frame rewrites all of it before it is scanned.
// ----------------------------------------------------------------------------
module motor_feedback_frame_parser_unit
    import mfp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Byte input.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] byte_in
    // Result output.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [127:0]          m_tdata,   // [31:0] time_value, [63:32] left_count,
                                             // [95:64] right_count, [127:96] center_count
    output logic                  m_tuser    // [0] frame_ok
);

    localparam logic [ADDR_W-1:0] LAST_IDX   = ADDR_W'(FRAME_LAST_INDEX);
    localparam logic [ADDR_W-1:0] ADDR_HDR   = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_START = ADDR_W'(1);
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(SCAN_END);
    localparam logic [STEP_W-1:0] STEP_EVAL  = STEP_W'(6);
    localparam logic [STEP_W-1:0] STEP_RDMAX = STEP_W'(FRAME_LAST_INDEX);
    localparam logic [STEP_W-1:0] STEP_ZERO  = STEP_W'(FRAME_LAST_INDEX + 2);

    mfp_state_t state_reg, state_next;

    logic [BYTE_W-1:0] header_char_reg, start_char_reg, end_char_reg;
    logic [BYTE_W-1:0] left_tag_reg, right_tag_reg, center_tag_reg;

    logic              in_frame_reg;
    logic [ADDR_W-1:0] widx_reg;
    logic [BYTE_W-1:0] prev_reg;
    logic              ok_reg;
    logic [STEP_W-1:0] step_reg, step_next;

    logic              m_tvalid_reg;
    logic [127:0]      m_tdata_reg;
    logic              m_tuser_reg;

    logic              s_fire;
    logic [BYTE_W-1:0] byte_in;
    logic [ADDR_W-1:0] widx_inc;
    logic              frame_start;
    logic              frame_close;
    logic              close_ok;
    logic              emit_load;
    logic              scan_done;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    scan_ctrl_t        scan_ctrl;
    logic [BYTE_W-1:0] scan_byte;
    mfp_tags_t         tags;
    logic              crlf_hit;
    logic [VALUE_W-1:0] held_time, held_left, held_right, held_center;

    assign byte_in     = s_tdata;
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign widx_inc    = widx_reg + ADDR_W'(1);
    assign frame_start = !in_frame_reg && (byte_in == start_char_reg)
                         && (prev_reg == header_char_reg);
    assign frame_close = in_frame_reg && (widx_inc >= LAST_IDX);
    assign close_ok    = frame_close && (byte_in == end_char_reg);
    assign emit_load   = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign scan_done   = crlf_hit || (step_reg == STEP_LAST);

    assign tags.time_tag   = start_char_reg;
    assign tags.left_tag   = left_tag_reg;
    assign tags.right_tag  = right_tag_reg;
    assign tags.center_tag = center_tag_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_char_reg <= 8'd42;
            start_char_reg  <= 8'd84;
            end_char_reg    <= 8'd35;
            left_tag_reg    <= 8'd76;
            right_tag_reg   <= 8'd82;
            center_tag_reg  <= 8'd90;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_HEADER_CHAR: header_char_reg <= cfg_wdata;
                CFG_START_CHAR:  start_char_reg  <= cfg_wdata;
                CFG_END_CHAR:    end_char_reg    <= cfg_wdata;
                CFG_LEFT_TAG:    left_tag_reg    <= cfg_wdata;
                CFG_RIGHT_TAG:   right_tag_reg   <= cfg_wdata;
                CFG_CENTER_TAG:  center_tag_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                priority if (s_fire && frame_start) begin
                    state_next = ST_HDR;
                end else if (s_fire && close_ok) begin
                    state_next = ST_SCAN;
                end else if (s_fire && frame_close) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_HDR: state_next = ST_IDLE;
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Store writes, scan reads and window control.
    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = widx_inc;
        ram_wdata       = byte_in;
        ram_raddr       = ADDR_HDR;
        scan_ctrl.shift = 1'b0;
        scan_ctrl.eval  = 1'b0;
        scan_byte       = '0;
        step_next       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && frame_start) begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_START;
                end else if (s_fire && in_frame_reg) begin
                    ram_we = 1'b1;
                end
            end
            ST_HDR: begin
                // The header byte equals the configured header character.
                ram_we    = 1'b1;
                ram_waddr = ADDR_HDR;
                ram_wdata = header_char_reg;
            end
            ST_SCAN: begin
                step_next       = step_reg + STEP_W'(1);
                ram_raddr       = (step_reg <= STEP_RDMAX) ? step_reg[ADDR_W-1:0] : ADDR_HDR;
                // Positions past the frame are not in the store; the window is fed zero for them.
                scan_byte       = (step_reg < STEP_ZERO) ? ram_rdata : '0;
                scan_ctrl.shift = (step_reg != '0);
                scan_ctrl.eval  = (step_reg >= STEP_EVAL);
            end
            ST_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_frame_reg <= 1'b0;
            widx_reg     <= '0;
            prev_reg     <= '0;
            ok_reg       <= 1'b0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (s_fire) begin
                prev_reg <= byte_in;
                if (frame_start) begin
                    in_frame_reg <= 1'b1;
                    widx_reg     <= ADDR_START;
                end else if (frame_close) begin
                    in_frame_reg <= 1'b0;
                    widx_reg     <= '0;
                    ok_reg       <= close_ok;
                end else if (in_frame_reg) begin
                    widx_reg <= widx_inc;
                end
            end
            if (emit_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_tuser_reg <= ok_reg;
            m_tdata_reg <= {held_center, held_right, held_left, held_time};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    mfp_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    mfp_scan_unit u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (scan_ctrl),
        .scan_byte   (scan_byte),
        .tags        (tags),
        .held_time   (held_time),
        .held_left   (held_left),
        .held_right  (held_right),
        .held_center (held_center),
        .crlf_hit    (crlf_hit)
    );

    // The scan never runs past its last step.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (step_reg <= STEP_LAST))
        else $error("scan step beyond last position");

    // Held values change only while a frame is being scanned.
    a_held_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN) |=> ($stable(held_time) && $stable(held_left)
                                    && $stable(held_right) && $stable(held_center)))
        else $error("held value changed outside a scan");

    // An open frame always has room for its next byte.
    a_widx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (widx_reg < LAST_IDX))
        else $error("write index reached the last position inside a frame");

    // A result leaves the output register only through a completed transaction.
    a_result_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready && !emit_load) |=> m_tvalid_reg)
        else $error("result dropped without a transaction");

endmodule
